>>> rtl/flvdf_pkg.sv
package flvdf_pkg;

   // Byte counts and positions inside one tag.
   localparam int unsigned CountWidth = 24;
   localparam logic [CountWidth-1:0] TAG_HDR_LAST_POS = 24'd10;
   localparam logic [CountWidth-1:0] TRAILER_LAST_POS = 24'd3;
   localparam logic [CountWidth-1:0] TYPE_POS         = 24'd0;
   localparam logic [CountWidth-1:0] LENGTH_LAST_POS  = 24'd3;
   localparam logic [CountWidth-1:0] EXT_BYTE_POS     = 24'd7;

   // Tag type codes that carry media.
   localparam logic [7:0] TYPE_AUDIO = 8'h08;
   localparam logic [7:0] TYPE_VIDEO = 8'h09;

   // Request command codes.
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Result kind codes.
   localparam logic KIND_AUDIO = 1'b0;
   localparam logic KIND_VIDEO = 1'b1;

   // Parser phases, one-hot.
   typedef enum logic [3:0] {
      PH_FILE_HDR = 4'b0001,
      PH_TAG_HDR  = 4'b0010,
      PH_PAYLOAD  = 4'b0100,
      PH_TRAILER  = 4'b1000
   } phase_type;

   // One result beat.
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        tag_kind;
      logic [23:0] tag_time;
      logic        last_of_tag;
   } rsp_type;

endpackage

>>> rtl/flvdf_parser.sv
module flvdf_parser #(
   parameter int unsigned HEADER_BYTES = 13
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 beat_accept,
   input  logic                 command,
   input  logic [7:0]           data_byte,
   output logic                 result_valid,
   output flvdf_pkg::rsp_type   result
);

   localparam logic [flvdf_pkg::CountWidth-1:0] HdrLastPos =
      flvdf_pkg::CountWidth'(HEADER_BYTES - 1);

   flvdf_pkg::phase_type phase_ff, phase_in;
   logic [flvdf_pkg::CountWidth-1:0] count_ff, count_in;
   logic [7:0]  type_ff, type_in;
   logic [23:0] length_ff, length_in;
   logic [23:0] stamp_ff, stamp_in;
   logic [flvdf_pkg::CountWidth-1:0] count_inc;
   logic        media_tag;
   logic        last_byte;

   assign count_inc = count_ff + 1'b1;
   assign media_tag = (type_ff == flvdf_pkg::TYPE_AUDIO) ||
                      (type_ff == flvdf_pkg::TYPE_VIDEO);
   assign last_byte = (count_inc == length_ff);

   // Next-state logic for the phase machine and the tag fields.
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      type_in   = type_ff;
      length_in = length_ff;
      stamp_in  = stamp_ff;
      if (beat_accept) begin
         if (command == flvdf_pkg::CMD_RESTART) begin
            phase_in  = flvdf_pkg::PH_FILE_HDR;
            count_in  = '0;
            type_in   = '0;
            length_in = '0;
            stamp_in  = '0;
         end else begin
            case (phase_ff)
               flvdf_pkg::PH_FILE_HDR: begin
                  if (count_ff == HdrLastPos) begin
                     phase_in = flvdf_pkg::PH_TAG_HDR;
                     count_in = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end
               flvdf_pkg::PH_TAG_HDR: begin
                  // Type byte, then three length bytes, then three timestamp bytes.
                  if (count_ff == flvdf_pkg::TYPE_POS) begin
                     type_in = data_byte;
                  end else if (count_ff <= flvdf_pkg::LENGTH_LAST_POS) begin
                     length_in = {length_ff[15:0], data_byte};
                  end else if (count_ff < flvdf_pkg::EXT_BYTE_POS) begin
                     stamp_in = {stamp_ff[15:0], data_byte};
                  end
                  if (count_ff == flvdf_pkg::TAG_HDR_LAST_POS) begin
                     phase_in = (length_ff == '0) ? flvdf_pkg::PH_TRAILER
                                                  : flvdf_pkg::PH_PAYLOAD;
                     count_in = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end
               flvdf_pkg::PH_PAYLOAD: begin
                  if (last_byte) begin
                     phase_in = flvdf_pkg::PH_TRAILER;
                     count_in = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end
               flvdf_pkg::PH_TRAILER: begin
                  if (count_ff == flvdf_pkg::TRAILER_LAST_POS) begin
                     phase_in  = flvdf_pkg::PH_TAG_HDR;
                     count_in  = '0;
                     type_in   = '0;
                     length_in = '0;
                     stamp_in  = '0;
                  end else begin
                     count_in = count_inc;
                  end
               end
               default: begin
                  phase_in = flvdf_pkg::PH_FILE_HDR;
                  count_in = '0;
               end
            endcase
         end
      end
   end

   // A media payload byte produces one result beat.
   assign result_valid = beat_accept && (command == flvdf_pkg::CMD_BYTE) &&
                         (phase_ff == flvdf_pkg::PH_PAYLOAD) && media_tag;
   assign result.payload_byte = data_byte;
   assign result.tag_kind     = (type_ff == flvdf_pkg::TYPE_VIDEO) ?
                                flvdf_pkg::KIND_VIDEO : flvdf_pkg::KIND_AUDIO;
   assign result.tag_time     = stamp_ff;
   assign result.last_of_tag  = last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= flvdf_pkg::PH_FILE_HDR;
         count_ff  <= '0;
         type_ff   <= '0;
         length_ff <= '0;
         stamp_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         type_ff   <= type_in;
         length_ff <= length_in;
         stamp_ff  <= stamp_in;
      end
   end

endmodule

>>> rtl/flvdf_out_stage.sv
module flvdf_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  flvdf_pkg::rsp_type  in_data,
   output logic                in_ready,
   output logic                out_valid,
   output flvdf_pkg::rsp_type  out_data,
   input  logic                out_ready
);

   logic               main_valid_ff, main_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   flvdf_pkg::rsp_type main_data_ff, main_data_in;
   flvdf_pkg::rsp_type skid_data_ff, skid_data_in;
   logic               main_free;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;
   assign main_free = !main_valid_ff || out_ready;

   // Main register feeds the port; the skid register catches a beat
   // that arrives while the main register is stalled.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_data_in  = in_data;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

>>> rtl/flv_tag_deframer_top.sv
// Channel | Direction | tdata                                  | tuser    | tlast
// req     | in        | [7:0] data_byte                        | command  | -
// rsp     | out       | [7:0] payload_byte, [31:8] tag_time    | tag_kind | last_of_tag
//
// One request beat is taken per cycle while req_tready is high; the phase
// machine updates its state in the cycle of the beat; results are registered onto rsp.
// Reset is synchronous and active high; a restart command has the same
// effect on the parser state. A two-entry output stage lets one more beat
// in while a result is stalled, so req_tready drops only when both are full.
module flv_tag_deframer_top #(
   parameter int unsigned HEADER_BYTES = 13
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] payload_byte, [31:8] tag_time
   output logic        rsp_tuser,   // [0] tag_kind
   output logic        rsp_tlast    // last_of_tag
);

   logic               beat_accept;
   logic               result_valid;
   flvdf_pkg::rsp_type result;
   flvdf_pkg::rsp_type out_data;

   assign beat_accept = req_tvalid && req_tready;

   flvdf_parser #(
      .HEADER_BYTES(HEADER_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .beat_accept  (beat_accept),
      .command      (req_tuser),
      .data_byte    (req_tdata),
      .result_valid (result_valid),
      .result       (result)
   );

   flvdf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (result_valid),
      .in_data   (result),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .out_ready (rsp_tready)
   );

   // Pack the result beat onto the stream ports.
   assign rsp_tdata = {out_data.tag_time, out_data.payload_byte};
   assign rsp_tuser = out_data.tag_kind;
   assign rsp_tlast = out_data.last_of_tag;

endmodule
